FILE: hdl/lobm_pkg.sv
`timescale 1ns / 1ps
package lobm_pkg;

  localparam int unsigned DEF_PRICE_LEVELS = 1024;
  localparam int unsigned DEF_ORDER_SLOTS  = 1024;
  localparam int unsigned DEF_ID_BITS      = 12;
  localparam int unsigned DEF_QTY_BITS     = 32;

  localparam int unsigned PRICE_W  = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned FILLS_W  = 11;
  localparam int unsigned TOTAL_W  = 32;
  localparam int unsigned ROW_W    = 32;
  localparam int unsigned BIT_W    = $clog2(ROW_W);

  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_PRICE = 3'd1;
  localparam logic [STATUS_W-1:0] ST_POOL_FULL = 3'd2;
  localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd4;

  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_CANCEL = 1'b1;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_ACHK, S_A1, S_A2, S_M0, S_M1, S_M2, S_M3, S_M4, S_M5,
    S_U0, S_U1, S_U2, S_C0, S_C1, S_DONE
  } state_e;

  typedef enum logic [4:0] {
    OP_IDLE, OP_CLEAR, OP_LOAD, OP_ADD_CHK, OP_ADD_WR1, OP_ADD_WR2, OP_ROW_RD,
    OP_HEAD_RD, OP_BAMT_RD, OP_AAMT_RD, OP_TRADE, OP_AAMT_WR, OP_SLOT_RD,
    OP_UNLINK, OP_FREE, OP_ID_RD, OP_ID_CHK
  } op_e;

  typedef struct packed {
    logic clr_last;
    logic price_bad;
    logic pool_empty;
    logic no_book;
    logic lvl_gap;
    logic id_missing;
    logic bid_zero;
    logic ask_zero;
    logic pend;
    logic is_cancel;
  } dp_stat_t;

endpackage

FILE: hdl/lobm_ctrl.sv
`timescale 1ns / 1ps
module lobm_ctrl import lobm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  input  logic     req_type_i,
  input  dp_stat_t stat_i,
  output logic     busy,
  output logic     done_o,
  output op_e      op_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    op_o    = OP_IDLE;
    busy    = 1'b1;
    done_o  = 1'b0;
    case (state_q)
      S_CLR: begin
        op_o = OP_CLEAR;
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          op_o    = OP_LOAD;
          state_d = (req_type_i == REQ_CANCEL) ? S_C0 : S_ACHK;
        end
      end
      S_ACHK: begin
        op_o    = OP_ADD_CHK;
        state_d = (stat_i.price_bad || stat_i.pool_empty) ? S_DONE : S_A1;
      end
      S_A1: begin
        op_o    = OP_ADD_WR1;
        state_d = S_A2;
      end
      S_A2: begin
        op_o    = OP_ADD_WR2;
        state_d = S_M0;
      end
      S_M0: begin
        op_o    = OP_ROW_RD;
        state_d = stat_i.no_book ? S_DONE : S_M1;
      end
      S_M1: begin
        op_o    = OP_HEAD_RD;
        state_d = stat_i.lvl_gap ? S_DONE : S_M2;
      end
      S_M2: begin
        op_o    = OP_BAMT_RD;
        state_d = S_M3;
      end
      S_M3: begin
        op_o    = OP_AAMT_RD;
        state_d = S_M4;
      end
      S_M4: begin
        op_o    = OP_TRADE;
        state_d = S_M5;
      end
      S_M5: begin
        op_o    = OP_AAMT_WR;
        state_d = (stat_i.bid_zero || stat_i.ask_zero) ? S_U0 : S_M0;
      end
      S_U0: begin
        op_o    = OP_SLOT_RD;
        state_d = S_U1;
      end
      S_U1: begin
        op_o    = OP_UNLINK;
        state_d = S_U2;
      end
      S_U2: begin
        op_o = OP_FREE;
        if (stat_i.is_cancel) begin
          state_d = S_DONE;
        end else if (stat_i.pend) begin
          state_d = S_U0;
        end else begin
          state_d = S_M0;
        end
      end
      S_C0: begin
        op_o    = OP_ID_RD;
        state_d = S_C1;
      end
      S_C1: begin
        op_o    = OP_ID_CHK;
        state_d = stat_i.id_missing ? S_DONE : S_U1;
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted transfer did not raise busy");

  a_clr_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_CLR) |=> (state_q != S_CLR)) else $error("clear pass re-entered");

endmodule

FILE: hdl/lobm_dp.sv
`timescale 1ns / 1ps
module lobm_dp import lobm_pkg::*; #(
  parameter int unsigned PRICE_LEVELS = DEF_PRICE_LEVELS,
  parameter int unsigned ORDER_SLOTS  = DEF_ORDER_SLOTS,
  parameter int unsigned ID_BITS      = DEF_ID_BITS,
  parameter int unsigned QTY_BITS     = DEF_QTY_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  op_e                 op_i,
  input  logic                req_type_i,
  input  logic [ID_BITS-1:0]  order_id_i,
  input  logic [PRICE_W-1:0]  price_i,
  input  logic [QTY_BITS-1:0] quantity_i,
  input  logic                is_buy_i,
  output dp_stat_t            stat_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [FILLS_W-1:0]  fills_o,
  output logic [TOTAL_W-1:0]  trade_total_o
);

  localparam int unsigned LW   = $clog2(ORDER_SLOTS + 1);
  localparam int unsigned SW   = $clog2(ORDER_SLOTS);
  localparam int unsigned PW   = $clog2(PRICE_LEVELS);
  localparam int unsigned NROW = (PRICE_LEVELS + ROW_W - 1) / ROW_W;
  localparam int unsigned RB   = (NROW > 1) ? $clog2(NROW) : 1;
  localparam int unsigned LXW  = RB + BIT_W;
  localparam int unsigned IDN  = 1 << ID_BITS;
  localparam int unsigned MX1  = (ORDER_SLOTS > PRICE_LEVELS) ? ORDER_SLOTS : PRICE_LEVELS;
  localparam int unsigned CLRN = (MX1 > IDN) ? MX1 : IDN;
  localparam int unsigned CW   = $clog2(CLRN);
  localparam logic [LW-1:0] NIL = LW'(ORDER_SLOTS);

  // memories
  logic [ID_BITS-1:0]  sid_m   [ORDER_SLOTS];
  logic [PW-1:0]       slv_m   [ORDER_SLOTS];
  logic                sside_m [ORDER_SLOTS];
  logic [LW-1:0]       sback_m [ORDER_SLOTS];
  logic [LW-1:0]       sfwd_m  [ORDER_SLOTS];
  logic [QTY_BITS-1:0] samt_m  [ORDER_SLOTS];
  logic [LW-1:0]       bhead_m [PRICE_LEVELS];
  logic [LW-1:0]       btail_m [PRICE_LEVELS];
  logic [LW-1:0]       ahead_m [PRICE_LEVELS];
  logic [LW-1:0]       atail_m [PRICE_LEVELS];
  logic [LW-1:0]       i2s_m   [IDN];
  logic [ROW_W-1:0]    bocc_m  [NROW];
  logic [ROW_W-1:0]    aocc_m  [NROW];

  logic [ID_BITS-1:0]  sid_rd;
  logic [PW-1:0]       slv_rd;
  logic                sside_rd;
  logic [LW-1:0]       sback_rd, sfwd_rd, bhead_rd, btail_rd, ahead_rd, atail_rd, i2s_rd;
  logic [QTY_BITS-1:0] samt_rd;
  logic [ROW_W-1:0]    bocc_rd, aocc_rd;
  logic [RB-1:0]       bocc_ra_q, aocc_ra_q;

  // registers
  logic                req_q, buy_q, side_q, bz_q, az_q, pend_q;
  logic [ID_BITS-1:0]  id_q, ident_q;
  logic [PRICE_W-1:0]  price_q;
  logic [QTY_BITS-1:0] qty_q, bq_q, arem_q;
  logic [LW-1:0]       pool_q, s_q, t_q, bs_q, as_q, b_q, f_q;
  logic [PW-1:0]       lv_q;
  logic [RB-1:0]       brow_q, arow_q;
  logic [STATUS_W-1:0] status_q;
  logic [FILLS_W-1:0]  fills_q;
  logic [TOTAL_W-1:0]  total_q;
  logic [CW-1:0]       clr_q;
  logic [NROW-1:0]     bsum_q, bsum_d, asum_q, asum_d;

  // control of memory ports
  logic                slot_we, slot_re, samt_we, samt_re, sback_we, sfwd_we, sfwd_re;
  logic [SW-1:0]       slot_ra, samt_wa, samt_ra, sback_wa, sfwd_wa, sfwd_ra;
  logic [QTY_BITS-1:0] samt_wd;
  logic [LW-1:0]       sback_wd, sfwd_wd, hd_wd, tl_wd, i2s_wd;
  logic                hd_we, hd_side, hd_both, hd_re, tl_we, tl_side, tl_re;
  logic [PW-1:0]       hd_wa, tl_wa;
  logic                i2s_we, i2s_re;
  logic [ID_BITS-1:0]  i2s_wa, i2s_ra;
  logic                oc_we, oc_side, oc_re;
  logic [RB-1:0]       oc_wa, oc_ra_b, oc_ra_a;
  logic [ROW_W-1:0]    oc_wd, oc_v, bocc_v, aocc_v;

  // derived values
  logic [PW-1:0]       price_lv;
  logic [LXW-1:0]      price_x, slv_x, lv_x, bl_c, al_c;
  logic [RB-1:0]       brow_c, arow_c;
  logic [BIT_W-1:0]    bbit_c, abit_c;
  logic [LW-1:0]       tail_c;
  logic [QTY_BITS-1:0] trade_q;
  logic [SW-1:0]       s_slot;
  logic                clr_os, clr_pl, clr_id;

  assign price_lv = price_q[PW-1:0];
  assign price_x  = LXW'(price_lv);
  assign slv_x    = LXW'(slv_rd);
  assign lv_x     = LXW'(lv_q);
  assign s_slot   = s_q[SW-1:0];
  assign tail_c   = buy_q ? btail_rd : atail_rd;
  assign bocc_v   = bsum_q[bocc_ra_q] ? bocc_rd : '0;
  assign aocc_v   = asum_q[aocc_ra_q] ? aocc_rd : '0;
  assign oc_v     = oc_side ? bocc_v : aocc_v;
  assign bl_c     = {brow_q, bbit_c};
  assign al_c     = {arow_q, abit_c};
  assign trade_q  = (bq_q < samt_rd) ? bq_q : samt_rd;
  assign clr_os   = 32'(clr_q) < ORDER_SLOTS;
  assign clr_pl   = 32'(clr_q) < PRICE_LEVELS;
  assign clr_id   = 32'(clr_q) < IDN;

  // best bid is the highest occupied level, best ask the lowest
  always_comb begin
    brow_c = '0;
    arow_c = '0;
    bbit_c = '0;
    abit_c = '0;
    for (int i = 0; i < NROW; i++) if (bsum_q[i]) brow_c = RB'(i);
    for (int i = NROW - 1; i >= 0; i--) if (asum_q[i]) arow_c = RB'(i);
    for (int i = 0; i < ROW_W; i++) if (bocc_v[i]) bbit_c = BIT_W'(i);
    for (int i = ROW_W - 1; i >= 0; i--) if (aocc_v[i]) abit_c = BIT_W'(i);
  end

  always_comb begin
    slot_we  = 1'b0;
    slot_re  = 1'b0;
    slot_ra  = s_slot;
    samt_we  = 1'b0;
    samt_wa  = bs_q[SW-1:0];
    samt_wd  = qty_q;
    samt_re  = 1'b0;
    samt_ra  = as_q[SW-1:0];
    sback_we = 1'b0;
    sback_wa = s_slot;
    sback_wd = tail_c;
    sfwd_we  = 1'b0;
    sfwd_wa  = s_slot;
    sfwd_wd  = NIL;
    sfwd_re  = 1'b0;
    sfwd_ra  = s_slot;
    hd_we    = 1'b0;
    hd_side  = buy_q;
    hd_both  = 1'b0;
    hd_wa    = price_lv;
    hd_wd    = s_q;
    hd_re    = 1'b0;
    tl_we    = 1'b0;
    tl_side  = buy_q;
    tl_wa    = price_lv;
    tl_wd    = s_q;
    tl_re    = 1'b0;
    i2s_we   = 1'b0;
    i2s_wa   = id_q;
    i2s_wd   = s_q;
    i2s_re   = 1'b0;
    i2s_ra   = id_q;
    oc_we    = 1'b0;
    oc_side  = buy_q;
    oc_wa    = price_x[LXW-1:BIT_W];
    oc_wd    = oc_v | (ROW_W'(1) << price_x[BIT_W-1:0]);
    oc_re    = 1'b0;
    oc_ra_b  = price_x[LXW-1:BIT_W];
    oc_ra_a  = price_x[LXW-1:BIT_W];
    case (op_i)
      OP_CLEAR: begin
        sfwd_we = clr_os;
        sfwd_wa = clr_q[SW-1:0];
        sfwd_wd = LW'(32'(clr_q) + 1);
        hd_we   = clr_pl;
        tl_we   = clr_pl;
        hd_both = 1'b1;
        hd_wa   = clr_q[PW-1:0];
        tl_wa   = clr_q[PW-1:0];
        hd_wd   = NIL;
        tl_wd   = NIL;
        i2s_we  = clr_id;
        i2s_wa  = clr_q[ID_BITS-1:0];
        i2s_wd  = NIL;
      end
      OP_ADD_CHK: begin
        sfwd_re = 1'b1;
        sfwd_ra = pool_q[SW-1:0];
        tl_re   = 1'b1;
        oc_re   = 1'b1;
      end
      OP_ADD_WR1: begin
        slot_we  = 1'b1;
        samt_we  = 1'b1;
        samt_wa  = s_slot;
        sback_we = 1'b1;
        sfwd_we  = 1'b1;
        i2s_we   = 1'b1;
        tl_we    = 1'b1;
      end
      OP_ADD_WR2: begin
        if (t_q != NIL) begin
          sfwd_we = 1'b1;
          sfwd_wa = t_q[SW-1:0];
          sfwd_wd = s_q;
        end else begin
          hd_we = 1'b1;
          oc_we = 1'b1;
        end
      end
      OP_ROW_RD: begin
        oc_re   = 1'b1;
        oc_ra_b = brow_c;
        oc_ra_a = arow_c;
      end
      OP_HEAD_RD: begin
        hd_re = 1'b1;
      end
      OP_BAMT_RD: begin
        samt_re = 1'b1;
        samt_ra = bhead_rd[SW-1:0];
      end
      OP_AAMT_RD: begin
        samt_re = 1'b1;
      end
      OP_TRADE: begin
        samt_we = 1'b1;
        samt_wd = bq_q - trade_q;
      end
      OP_AAMT_WR: begin
        samt_we = 1'b1;
        samt_wa = as_q[SW-1:0];
        samt_wd = arem_q;
      end
      OP_SLOT_RD: begin
        slot_re = 1'b1;
        sfwd_re = 1'b1;
      end
      OP_ID_RD: begin
        i2s_re = 1'b1;
      end
      OP_ID_CHK: begin
        slot_re = 1'b1;
        slot_ra = i2s_rd[SW-1:0];
        sfwd_re = 1'b1;
        sfwd_ra = i2s_rd[SW-1:0];
      end
      OP_UNLINK: begin
        if (sback_rd != NIL) begin
          sfwd_we = 1'b1;
          sfwd_wa = sback_rd[SW-1:0];
          sfwd_wd = sfwd_rd;
        end else begin
          hd_we   = 1'b1;
          hd_side = sside_rd;
          hd_wa   = slv_rd;
          hd_wd   = sfwd_rd;
        end
        if (sfwd_rd != NIL) begin
          sback_we = 1'b1;
          sback_wa = sfwd_rd[SW-1:0];
          sback_wd = sback_rd;
        end else begin
          tl_we   = 1'b1;
          tl_side = sside_rd;
          tl_wa   = slv_rd;
          tl_wd   = sback_rd;
        end
        oc_re   = 1'b1;
        oc_ra_b = slv_x[LXW-1:BIT_W];
        oc_ra_a = slv_x[LXW-1:BIT_W];
        i2s_re  = 1'b1;
        i2s_ra  = sid_rd;
      end
      OP_FREE: begin
        if (b_q == NIL && f_q == NIL) begin
          oc_we   = 1'b1;
          oc_side = side_q;
          oc_wa   = lv_x[LXW-1:BIT_W];
          oc_wd   = oc_v & ~(ROW_W'(1) << lv_x[BIT_W-1:0]);
        end
        if (i2s_rd == s_q) begin
          i2s_we = 1'b1;
          i2s_wa = ident_q;
          i2s_wd = NIL;
        end
        sfwd_we = 1'b1;
        sfwd_wd = pool_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (slot_we) begin
      sid_m[s_slot]   <= id_q;
      slv_m[s_slot]   <= price_lv;
      sside_m[s_slot] <= buy_q;
    end
    if (slot_re) begin
      sid_rd   <= sid_m[slot_ra];
      slv_rd   <= slv_m[slot_ra];
      sside_rd <= sside_m[slot_ra];
      sback_rd <= sback_m[slot_ra];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sback_we) sback_m[sback_wa] <= sback_wd;
  end

  always_ff @(posedge clk_i) begin
    if (sfwd_we) sfwd_m[sfwd_wa] <= sfwd_wd;
    if (sfwd_re) sfwd_rd <= sfwd_m[sfwd_ra];
  end

  always_ff @(posedge clk_i) begin
    if (samt_we) samt_m[samt_wa] <= samt_wd;
    if (samt_re) samt_rd <= samt_m[samt_ra];
  end

  always_ff @(posedge clk_i) begin
    if (hd_we && (hd_side || hd_both)) bhead_m[hd_wa] <= hd_wd;
    if (hd_re) bhead_rd <= bhead_m[bl_c[PW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (hd_we && (!hd_side || hd_both)) ahead_m[hd_wa] <= hd_wd;
    if (hd_re) ahead_rd <= ahead_m[al_c[PW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (tl_we && (tl_side || hd_both)) btail_m[tl_wa] <= tl_wd;
    if (tl_re) btail_rd <= btail_m[price_lv];
  end

  always_ff @(posedge clk_i) begin
    if (tl_we && (!tl_side || hd_both)) atail_m[tl_wa] <= tl_wd;
    if (tl_re) atail_rd <= atail_m[price_lv];
  end

  always_ff @(posedge clk_i) begin
    if (i2s_we) i2s_m[i2s_wa] <= i2s_wd;
    if (i2s_re) i2s_rd <= i2s_m[i2s_ra];
  end

  always_ff @(posedge clk_i) begin
    if (oc_we && oc_side) bocc_m[oc_wa] <= oc_wd;
    if (oc_re) begin
      bocc_rd   <= bocc_m[oc_ra_b];
      bocc_ra_q <= oc_ra_b;
    end
  end

  always_ff @(posedge clk_i) begin
    if (oc_we && !oc_side) aocc_m[oc_wa] <= oc_wd;
    if (oc_re) begin
      aocc_rd   <= aocc_m[oc_ra_a];
      aocc_ra_q <= oc_ra_a;
    end
  end

  // level summary: one bit per bitmap row, set iff the row is non-empty
  always_comb begin
    bsum_d = bsum_q;
    asum_d = asum_q;
    if (oc_we) begin
      if (oc_side) begin
        bsum_d[oc_wa] = |oc_wd;
      end else begin
        asum_d[oc_wa] = |oc_wd;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q  <= '0;
      total_q <= '0;
      clr_q   <= '0;
      bsum_q  <= '0;
      asum_q  <= '0;
    end else begin
      bsum_q <= bsum_d;
      asum_q <= asum_d;
      case (op_i)
        OP_CLEAR:   clr_q   <= clr_q + CW'(1);
        OP_ADD_WR1: pool_q  <= sfwd_rd;
        OP_FREE:    pool_q  <= s_q;
        OP_TRADE:   total_q <= total_q + TOTAL_W'(1);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (op_i)
      OP_LOAD: begin
        req_q   <= req_type_i;
        id_q    <= order_id_i;
        price_q <= price_i;
        qty_q   <= quantity_i;
        buy_q   <= is_buy_i;
        fills_q <= '0;
        pend_q  <= 1'b0;
      end
      OP_ADD_CHK: begin
        s_q <= pool_q;
        if (stat_o.price_bad) begin
          status_q <= ST_BAD_PRICE;
        end else if (stat_o.pool_empty) begin
          status_q <= ST_POOL_FULL;
        end else begin
          status_q <= ST_ADDED;
        end
      end
      OP_ADD_WR1: t_q <= tail_c;
      OP_ROW_RD: begin
        brow_q <= brow_c;
        arow_q <= arow_c;
      end
      OP_BAMT_RD: begin
        bs_q <= bhead_rd;
        as_q <= ahead_rd;
      end
      OP_AAMT_RD: bq_q <= samt_rd;
      OP_TRADE: begin
        arem_q <= samt_rd - trade_q;
        bz_q   <= bq_q <= samt_rd;
        az_q   <= samt_rd <= bq_q;
        if (fills_q != '1) fills_q <= fills_q + FILLS_W'(1);
      end
      OP_AAMT_WR: begin
        s_q    <= bz_q ? bs_q : as_q;
        pend_q <= bz_q && az_q;
      end
      OP_ID_CHK: begin
        s_q      <= i2s_rd;
        status_q <= (i2s_rd == NIL) ? ST_NOT_FOUND : ST_CANCELLED;
      end
      OP_UNLINK: begin
        lv_q    <= slv_rd;
        side_q  <= sside_rd;
        b_q     <= sback_rd;
        f_q     <= sfwd_rd;
        ident_q <= sid_rd;
      end
      OP_FREE: begin
        if (pend_q) begin
          s_q    <= as_q;
          pend_q <= 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat_o.clr_last   = clr_q == CW'(CLRN - 1);
  assign stat_o.price_bad  = {1'b0, price_q} >= (PRICE_W + 1)'(PRICE_LEVELS);
  assign stat_o.pool_empty = pool_q == NIL;
  assign stat_o.no_book    = !(|bsum_q) || !(|asum_q) || (brow_c < arow_c);
  assign stat_o.lvl_gap    = bl_c < al_c;
  assign stat_o.id_missing = i2s_rd == NIL;
  assign stat_o.bid_zero   = bz_q;
  assign stat_o.ask_zero   = az_q;
  assign stat_o.pend       = pend_q;
  assign stat_o.is_cancel  = req_q;

  assign status_o      = status_q;
  assign fills_o       = fills_q;
  assign trade_total_o = total_q;

  a_pool_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pool_q <= NIL) else $error("free list head out of range");

  a_trade_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (op_i == OP_TRADE) |=> (total_q - $past(total_q) == TOTAL_W'(1)))
    else $error("trade counter did not advance on a trade");

endmodule

FILE: hdl/limit_order_book_matcher.sv
`timescale 1ns / 1ps
// channel   direction  handshake                 payload
// request   in         start high, busy low      req_type_i order_id_i price_i quantity_i is_buy_i
// result    out        done_o one-cycle strobe   status_o fills_o trade_total_o
//
// after reset a clearing pass over max(ORDER_SLOTS, PRICE_LEVELS, 2**ID_BITS) entries runs
// (4096 at the defaults) with busy high
// rejected add: price and pool check, then the strobe; cancel: id lookup, then unlink and free,
// both skipped when the id is unknown; booked add: check and two writes, then trades with order
// freeing until the row compare or the level compare inside one bitmap row stops matching
// one item at a time; busy stays high until the result strobe, which cannot be stalled
module limit_order_book_matcher import lobm_pkg::*; #(
  parameter int unsigned PRICE_LEVELS = DEF_PRICE_LEVELS,
  parameter int unsigned ORDER_SLOTS  = DEF_ORDER_SLOTS,
  parameter int unsigned ID_BITS      = DEF_ID_BITS,
  parameter int unsigned QTY_BITS     = DEF_QTY_BITS
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  logic                req_type_i,
  input  logic [ID_BITS-1:0]  order_id_i,
  input  logic [PRICE_W-1:0]  price_i,
  input  logic [QTY_BITS-1:0] quantity_i,
  input  logic                is_buy_i,
  output logic                done_o,
  output logic [STATUS_W-1:0] status_o,
  output logic [FILLS_W-1:0]  fills_o,
  output logic [TOTAL_W-1:0]  trade_total_o
);

  op_e      op;
  dp_stat_t stat;

  lobm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .busy       (busy),
    .done_o     (done_o),
    .op_o       (op)
  );

  lobm_dp #(
    .PRICE_LEVELS (PRICE_LEVELS),
    .ORDER_SLOTS  (ORDER_SLOTS),
    .ID_BITS      (ID_BITS),
    .QTY_BITS     (QTY_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .req_type_i    (req_type_i),
    .order_id_i    (order_id_i),
    .price_i       (price_i),
    .quantity_i    (quantity_i),
    .is_buy_i      (is_buy_i),
    .stat_o        (stat),
    .status_o      (status_o),
    .fills_o       (fills_o),
    .trade_total_o (trade_total_o)
  );

endmodule
